// File: rtl/core/olx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olx_pkg: shared types and constants of the operator and integer lexer
// Byte and token transaction types, token kinds, character codes and the
// depth of the token queue between the front and back parts.
// ----------------------------------------------------------------------------
package olx_pkg;

    // Input transaction: one source byte plus end-of-input marker
    typedef struct packed {
        logic [7:0] char_code;
        logic       final_byte;
    } t_in;

    // Output transaction: one token
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] int_value;
        logic        overflowed;
        logic [7:0]  bad_char;
        logic        last_of_run;
    } t_token;

    // Front to queue: up to two tokens per accepted byte
    typedef struct packed {
        logic [1:0]         cnt;
        t_token [1:0]       tok;
    } t_push;

    // Token kinds
    typedef enum logic [3:0] {
        KIND_EOL    = 4'd0,
        KIND_INT    = 4'd1,
        KIND_NE     = 4'd2,
        KIND_BANG   = 4'd3,
        KIND_POUND  = 4'd4,
        KIND_LPAREN = 4'd5,
        KIND_RPAREN = 4'd6,
        KIND_PLUS   = 4'd7,
        KIND_LE     = 4'd8,
        KIND_LT     = 4'd9,
        KIND_EQEQ   = 4'd10,
        KIND_ASSIGN = 4'd11,
        KIND_GE     = 4'd12,
        KIND_GT     = 4'd13,
        KIND_ERROR  = 4'd14
    } t_kind;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_POUND  = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // Token queue
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: rtl/core/olx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olx_front: byte classifier and lexer state
// Accepts one byte per cycle while the queue has room, updates the lexer
// mode, pending operator and digit accumulator, and hands zero to two tokens to the token queue.
// ----------------------------------------------------------------------------
module olx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  olx_pkg::t_in  i_in,
    input  logic          i_space_ok,
    output olx_pkg::t_push o_push
);
    import olx_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_OP   = 2'd2,
        MODE_ERR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_BANG = 2'd0,
        OP_LT   = 2'd1,
        OP_EQ   = 2'd2,
        OP_GT   = 2'd3
    } t_op;

    // One-character token of a pending operator
    function automatic logic [3:0] op_single(input t_op op);
        logic [3:0] k;
        case (op)
            OP_BANG: k = KIND_BANG;
            OP_LT:   k = KIND_LT;
            OP_EQ:   k = KIND_ASSIGN;
            OP_GT:   k = KIND_GT;
            default: k = KIND_BANG;
        endcase
        return k;
    endfunction

    // Two-character token of a pending operator followed by '='
    function automatic logic [3:0] op_double(input t_op op);
        logic [3:0] k;
        case (op)
            OP_BANG: k = KIND_NE;
            OP_LT:   k = KIND_LE;
            OP_EQ:   k = KIND_EQEQ;
            OP_GT:   k = KIND_GE;
            default: k = KIND_NE;
        endcase
        return k;
    endfunction

    function automatic t_token mk_tok(input logic [3:0] kind, input logic [63:0] val,
                                      input logic ovf, input logic [7:0] bad);
        t_token t;
        t.token_kind  = kind;
        t.int_value   = val;
        t.overflowed  = ovf;
        t.bad_char    = bad;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    t_mode        r_mode, n_mode;
    t_op          r_pend, n_pend;
    logic [63:0]  r_acc, n_acc;
    logic         r_ovf, n_ovf;

    logic         accept;
    logic [7:0]   c;
    logic [7:0]   c_off;
    logic [3:0]   digit;
    logic         is_digit;
    logic [67:0]  mac_sum;
    logic         do_idle;
    logic [1:0]   cnt;
    t_token [1:0] tk;

    assign o_ready  = i_space_ok;
    assign accept   = i_valid && i_space_ok;
    assign c        = i_in.char_code;
    assign c_off    = c - CH_ZERO;
    assign digit    = c_off[3:0];
    assign is_digit = (c inside {[CH_ZERO:CH_NINE]});

    // acc * 10 + digit; anything above bit 63 is overflow
    assign mac_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {64'd0, digit};

    // Next lexer state and the tokens caused by this byte
    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        do_idle = 1'b0;
        cnt     = 2'd0;
        tk      = '0;

        case (r_mode)
            MODE_INT: begin
                if (is_digit) begin
                    n_acc = mac_sum[63:0];
                    n_ovf = r_ovf | (|mac_sum[67:64]);
                end else begin
                    tk[cnt[0]] = mk_tok(KIND_INT, r_acc, r_ovf, 8'd0);
                    cnt        = cnt + 2'd1;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                    n_mode     = MODE_IDLE;
                    do_idle    = 1'b1;
                end
            end
            MODE_OP: begin
                n_mode = MODE_IDLE;
                if (c == CH_EQ) begin
                    tk[cnt[0]] = mk_tok(op_double(r_pend), 64'd0, 1'b0, 8'd0);
                    cnt        = cnt + 2'd1;
                end else begin
                    tk[cnt[0]] = mk_tok(op_single(r_pend), 64'd0, 1'b0, 8'd0);
                    cnt        = cnt + 2'd1;
                    do_idle    = 1'b1;
                end
            end
            MODE_ERR: begin
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Lex the byte from idle
        if (do_idle) begin
            case (c)
                CH_SPACE, CH_TAB, CH_CR: begin
                end
                CH_LF, CH_POUND, CH_LPAREN, CH_RPAREN, CH_PLUS: begin
                    tk[cnt[0]] = mk_tok((c == CH_LF)     ? KIND_EOL    :
                                        (c == CH_POUND)  ? KIND_POUND  :
                                        (c == CH_LPAREN) ? KIND_LPAREN :
                                        (c == CH_RPAREN) ? KIND_RPAREN : KIND_PLUS,
                                        64'd0, 1'b0, 8'd0);
                    cnt        = cnt + 2'd1;
                end
                CH_BANG: begin n_mode = MODE_OP; n_pend = OP_BANG; end
                CH_LT:   begin n_mode = MODE_OP; n_pend = OP_LT;   end
                CH_EQ:   begin n_mode = MODE_OP; n_pend = OP_EQ;   end
                CH_GT:   begin n_mode = MODE_OP; n_pend = OP_GT;   end
                default: begin
                    if (is_digit) begin
                        n_mode = MODE_INT;
                        n_acc  = {60'd0, digit};
                        n_ovf  = 1'b0;
                    end else begin
                        tk[cnt[0]] = mk_tok(KIND_ERROR, 64'd0, 1'b0, c);
                        cnt        = cnt + 2'd1;
                        n_mode     = MODE_ERR;
                    end
                end
            endcase
        end

        // End of input: flush whatever is pending, then back to reset state
        if (i_in.final_byte) begin
            if (n_mode == MODE_INT && cnt != 2'd2) begin
                tk[cnt[0]] = mk_tok(KIND_INT, n_acc, n_ovf, 8'd0);
                cnt        = cnt + 2'd1;
            end else if (n_mode == MODE_OP && cnt != 2'd2) begin
                tk[cnt[0]] = mk_tok(op_single(n_pend), 64'd0, 1'b0, 8'd0);
                cnt        = cnt + 2'd1;
            end
            n_mode = MODE_IDLE;
            n_pend = OP_BANG;
            n_acc  = '0;
            n_ovf  = 1'b0;
        end

        // Mark the last token of this byte
        if (cnt != 2'd0) begin
            tk[cnt[1]].last_of_run = 1'b1;
        end
    end

    assign o_push.cnt = accept ? cnt : 2'd0;
    assign o_push.tok = tk;

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pend <= OP_BANG;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    // Error mode swallows bytes until the final marker
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == MODE_ERR) |-> (o_push.cnt == 2'd0))
        else $error("token produced while in error mode");

    // Final marker leaves the lexer in its reset state
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.final_byte) |=> (r_mode == MODE_IDLE && r_acc == 64'd0 && !r_ovf))
        else $error("lexer state not cleared after final byte");

    // Exactly the last token of a run carries the marker
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (!o_push.tok[0].last_of_run && o_push.tok[1].last_of_run))
        else $error("last_of_run misplaced on two-token byte");

endmodule

// File: rtl/core/olx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olx_fifo: token queue between front and back
// Small circular buffer that takes up to two tokens per cycle and gives one.
// Space is reported while at least two entries are free.
// ----------------------------------------------------------------------------
module olx_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  olx_pkg::t_push   i_push,
    output logic             o_space_ok,
    input  logic             i_pop,
    output logic             o_avail,
    output olx_pkg::t_token  o_head
);
    import olx_pkg::*;

    t_token               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, r_rp;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 do_pop;
    logic [QUEUE_AW-1:0]  wp_next;

    assign o_space_ok = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_avail    = (r_count != '0);
    assign o_head     = r_mem[r_rp];
    assign do_pop     = i_pop && o_avail;
    assign wp_next    = r_wp + QUEUE_AW'(1);

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.tok[0];
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp_next] <= i_push.tok[1];
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QUEUE_AW'(i_push.cnt);
            r_rp    <= r_rp + QUEUE_AW'(do_pop);
            r_count <= r_count + QUEUE_CW'(i_push.cnt) - QUEUE_CW'(do_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space_ok)
        else $error("token queue written without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("token queue count past depth");

endmodule

// File: rtl/core/olx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olx_back: token output stage
// Pulls tokens from the queue into the output register and presents them
// on the output channel, reloading in the same cycle one is taken.
// ----------------------------------------------------------------------------
module olx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  olx_pkg::t_token  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output olx_pkg::t_token  o_out
);
    import olx_pkg::*;

    logic   r_valid;
    t_token r_out;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_head;
        end
    end

endmodule

// File: rtl/core/operator_integer_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operator_integer_lexer: byte-stream lexer for integers and operators
// Top level: front lexer, four-entry token queue and output register.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle and emits newline, decimal
// integer, operator and error tokens, each byte causing zero, one or two
// tokens. The front part updates the lexer state in the cycle a byte is
// accepted and writes its tokens into a four-entry queue; the output
// register drains one token per cycle while the receiver is ready. Each
// token goes through the queue and then the output register. Input is
// accepted while two queue entries are free, so the sustained rate is one
// byte per cycle as long as the tokens average at most one per byte; the
// single output port sets that ceiling at one token per cycle.
// ----------------------------------------------------------------------------
module operator_integer_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  olx_pkg::t_in     i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output olx_pkg::t_token  o_out
);
    import olx_pkg::*;

    t_push  push;
    logic   space_ok;
    logic   avail;
    logic   pop;
    t_token head;

    olx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    olx_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .i_pop      (pop),
        .o_avail    (avail),
        .o_head     (head)
    );

    olx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

endmodule

// File: test/lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_checker: token predictor and scoreboard for the operator lexer
// Watches the byte and token channels, lexes every accepted byte with its
// own copy of the lexer state, queues the tokens it expects and compares
// each accepted token field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module lexer_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  olx_pkg::t_in    i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  olx_pkg::t_token i_out_data,
    output int              o_fail_count,
    output int              o_outstanding,
    output int              o_checked
);
    import olx_pkg::*;

    typedef enum logic [1:0] {MODE_IDLE, MODE_INT, MODE_OP, MODE_ERR} t_mode;
    typedef enum logic [1:0] {OP_BANG, OP_LT, OP_EQ, OP_GT} t_op;

    // Shadow lexer state
    t_mode       mode;
    t_op         op_held;
    logic [63:0] acc;
    logic        acc_ovf;

    // Tokens of the byte being lexed, then the queue of expected tokens
    t_token      byte_tok [2];
    int          byte_cnt;
    t_token      exp_tokens [$];
    int          fail_count = 0;
    int          checked = 0;

    function automatic t_kind single_kind(t_op p);
        case (p)
            OP_BANG: return KIND_BANG;
            OP_LT:   return KIND_LT;
            OP_EQ:   return KIND_ASSIGN;
            default: return KIND_GT;
        endcase
    endfunction

    function automatic t_kind double_kind(t_op p);
        case (p)
            OP_BANG: return KIND_NE;
            OP_LT:   return KIND_LE;
            OP_EQ:   return KIND_EQEQ;
            default: return KIND_GE;
        endcase
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    task automatic reset_state();
        mode    = MODE_IDLE;
        op_held = OP_BANG;
        acc     = '0;
        acc_ovf = 1'b0;
    endtask

    // At most two tokens per byte; a third would be dropped
    task automatic add_token(t_kind k, logic [63:0] v, logic ovf, logic [7:0] bad);
        if (byte_cnt < 2) begin
            byte_tok[byte_cnt] = '{token_kind: k, int_value: v, overflowed: ovf,
                                   bad_char: bad, last_of_run: 1'b0};
            byte_cnt++;
        end
    endtask

    // Wide multiply-add: anything above bit 63 means the literal wrapped
    task automatic add_digit(logic [7:0] c);
        logic [67:0] wide;
        wide = {4'd0, acc} * 68'd10 + {60'd0, (c - CH_ZERO)};
        if (wide[67:64] != 4'd0)
            acc_ovf = 1'b1;
        acc = wide[63:0];
    endtask

    task automatic flush_int();
        add_token(KIND_INT, acc, acc_ovf, 8'd0);
        acc     = '0;
        acc_ovf = 1'b0;
        mode    = MODE_IDLE;
    endtask

    task automatic lex_from_idle(logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:     add_token(KIND_EOL, 64'd0, 1'b0, 8'd0);
            CH_POUND:  add_token(KIND_POUND, 64'd0, 1'b0, 8'd0);
            CH_LPAREN: add_token(KIND_LPAREN, 64'd0, 1'b0, 8'd0);
            CH_RPAREN: add_token(KIND_RPAREN, 64'd0, 1'b0, 8'd0);
            CH_PLUS:   add_token(KIND_PLUS, 64'd0, 1'b0, 8'd0);
            CH_BANG: begin
                mode = MODE_OP; op_held = OP_BANG;
            end
            CH_LT: begin
                mode = MODE_OP; op_held = OP_LT;
            end
            CH_EQ: begin
                mode = MODE_OP; op_held = OP_EQ;
            end
            CH_GT: begin
                mode = MODE_OP; op_held = OP_GT;
            end
            default: begin
                if (is_digit(c)) begin
                    mode    = MODE_INT;
                    acc     = '0;
                    acc_ovf = 1'b0;
                    add_digit(c);
                end else begin
                    add_token(KIND_ERROR, 64'd0, 1'b0, c);
                    mode = MODE_ERR;
                end
            end
        endcase
    endtask

    // Lex one accepted byte and queue the tokens it causes
    task automatic lex_byte(t_in b);
        byte_cnt = 0;
        case (mode)
            MODE_INT: begin
                if (is_digit(b.char_code)) begin
                    add_digit(b.char_code);
                end else begin
                    flush_int();
                    lex_from_idle(b.char_code);
                end
            end
            MODE_OP: begin
                mode = MODE_IDLE;
                if (b.char_code == CH_EQ) begin
                    add_token(double_kind(op_held), 64'd0, 1'b0, 8'd0);
                end else begin
                    add_token(single_kind(op_held), 64'd0, 1'b0, 8'd0);
                    lex_from_idle(b.char_code);
                end
            end
            MODE_ERR: ;
            default: lex_from_idle(b.char_code);
        endcase

        // End of input flushes whatever is pending
        if (b.final_byte) begin
            if (mode == MODE_INT)
                flush_int();
            else if (mode == MODE_OP)
                add_token(single_kind(op_held), 64'd0, 1'b0, 8'd0);
            reset_state();
        end

        if (byte_cnt > 0)
            byte_tok[byte_cnt - 1].last_of_run = 1'b1;
        for (int i = 0; i < byte_cnt; i++)
            exp_tokens.push_back(byte_tok[i]);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH token %0d %s: got %0h expected %0h", checked, what, got, want);
        fail_count++;
    endtask

    task automatic check_token(t_token got);
        t_token want;
        if (exp_tokens.size() == 0) begin
            report_mismatch("unexpected token, kind", 64'(got.token_kind), 64'd0);
        end else begin
            want = exp_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report_mismatch("token_kind", 64'(got.token_kind),
                                64'(want.token_kind));
            if (got.int_value !== want.int_value)
                report_mismatch("int_value", got.int_value, want.int_value);
            if (got.overflowed !== want.overflowed)
                report_mismatch("overflowed", 64'(got.overflowed),
                                64'(want.overflowed));
            if (got.bad_char !== want.bad_char)
                report_mismatch("bad_char", 64'(got.bad_char), 64'(want.bad_char));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 64'(got.last_of_run),
                                64'(want.last_of_run));
        end
        checked++;
    endtask

    // Channel monitor: a token is never due at the edge its byte is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
            exp_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_token(i_out_data);
            if (i_in_valid && i_in_ready)
                lex_byte(i_in_data);
        end
        o_fail_count  <= fail_count;
        o_outstanding <= exp_tokens.size();
        o_checked     <= checked;
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the operator and integer lexer
// Feeds a directed byte sequence and then random source text made mostly of
// well-formed integers, operators and whitespace, with some noise bytes and
// end markers, under random gaps on both channels; the checker does the rest.
// ----------------------------------------------------------------------------
module testbench;
    import olx_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    t_in    in_data = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    t_token out_data;

    int     fail_count;
    int     outstanding;
    int     checked;
    int     sent = 0;
    bit     idle_on = 1'b0;
    int     stall_left = 0;

    localparam int RANDOM_BYTES = 1600;

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    operator_integer_lexer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_in    (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_out   (out_data)
    );

    lexer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Token side back-pressure
    always @(posedge clk) begin
        if (!idle_on) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    // One byte transaction; returns at the edge where it is taken
    task automatic send_byte(logic [7:0] c, logic fin);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_code: c, final_byte: fin};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    task automatic send_number();
        int pick;
        int len;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            send_text("18446744073709551615", 1'b0);
        end else if (pick == 1) begin
            send_text("18446744073709551616", 1'b0);
        end else begin
            len = (pick < 4) ? $urandom_range(19, 24) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    // One random piece of source text
    task automatic send_piece();
        logic [7:0] op_chars [8];
        logic [7:0] space_chars [3];
        int         pick;
        op_chars    = '{CH_BANG, CH_LT, CH_EQ, CH_GT, CH_POUND, CH_LPAREN, CH_RPAREN,
                        CH_PLUS};
        space_chars = '{CH_SPACE, CH_TAB, CH_CR};
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_number();
        end else if (pick < 62) begin
            send_byte(op_chars[$urandom_range(0, 7)], 1'b0);
            if ($urandom_range(0, 1) == 1)
                send_byte(CH_EQ, 1'b0);
        end else if (pick < 72) begin
            repeat ($urandom_range(1, 3))
                send_byte(space_chars[$urandom_range(0, 2)], 1'b0);
        end else if (pick < 78) begin
            send_byte(CH_LF, 1'b0);
        end else if (pick < 86) begin
            // Noise; an end marker soon after keeps ignored bytes few
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            // End marker on a token byte, often mid-operator or mid-number
            if ($urandom_range(0, 1) == 1)
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
            else
                send_byte(op_chars[$urandom_range(0, 7)], 1'b1);
        end
    endtask

    // Stimulus and verdict
    initial begin
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operator, whitespace, error paths, end-marker flushes
        send_text("!=!<<=>>=", 1'b0);
        send_text("===#()+", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("7", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("a", 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("5", 1'b1);
        send_text("<<", 1'b1);

        // Random text: first at full rate, then with gaps on both sides
        while (sent < 400)
            send_piece();
        idle_on = 1'b1;
        while (sent < RANDOM_BYTES)
            send_piece();
        send_byte(CH_LF, 1'b1);
        in_valid <= 1'b0;

        // Drain
        repeat (2) @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        idle_on = 1'b0;
        repeat (20) @(posedge clk);

        $display("Lexed %0d bytes of directed and random text, %0d tokens compared.",
                 sent, checked);
        if (outstanding != 0)
            $display("%0d expected tokens never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Timeout waiting for the lexer");
        $display("Some tests failed");
        $finish;
    end

endmodule
